// File: rtl/lifo_stack_with_search_assert.svh
// Assertion macros for the stack block and its port checker.
`ifndef LIFO_STACK_WITH_SEARCH_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define LSTK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define LSTK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define LSTK_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lstk_pkg.sv
`timescale 1ns / 1ps

package lstk_pkg;

    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 5;
    localparam int DEPTH_DEF = 16;

    localparam int S_TDATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - DATA_W - POS_W;
    localparam int M_TUSER_W = STATUS_W + 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_NOTFOUND  = 2'd3
    } status_t;

    localparam logic [DATA_W-1:0] DATA_UNDERFLOW = '1;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  position;
        status_t           status;
        logic              is_empty;
        logic              is_full;
    } result_t;

endpackage

// File: rtl/lifo_stack_with_search.sv
`timescale 1ns / 1ps
// Channel   | Beat when           | tdata (low bit up)          | tuser (low bit up)
// ----------+---------------------+-----------------------------+---------------------------
// s_ (cmd)  | s_tvalid & s_tready | value[31:0]                 | cmd[1:0]
// m_ (res)  | m_tvalid & m_tready | data[31:0], position[36:32] | status[1:0], is_empty[2],
//           |                     | zero pad [39:37]            | is_full[3]
//
// Steps per command, from accept to ready again: push goes to the finish step; pop
// and peek go through a read step first (not on an empty stack); search goes through
// one scan step per entry compared (none on an empty stack, else 1 to DEPTH); the
// search loop runs one compare per cycle through the single read port of the stack memory.
// Reset (aresetn low, synchronous) empties the stack and drops any pending result.
// A result waiting on m_tready holds the next one in the finish step; s_tready is
// low from accept until the result moves into the output register.
module lifo_stack_with_search #(
    parameter int DEPTH = lstk_pkg::DEPTH_DEF   // 2 to 31 entries
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // command channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lstk_pkg::S_TDATA_W-1:0] s_tdata,   // value
    input  logic [lstk_pkg::S_TUSER_W-1:0] s_tuser,   // cmd
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lstk_pkg::M_TDATA_W-1:0] m_tdata,   // data, position, zero pad
    output logic [lstk_pkg::M_TUSER_W-1:0] m_tuser    // status, is_empty, is_full
);
    import lstk_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    result_t           result;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;

    // Sequencer: count, search walk and output register.
    lstk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_cmd       (cmd_t'(s_tuser)),
        .s_value     (s_tdata[DATA_W-1:0]),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (result),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Stack storage: one write, one registered read per cycle; no clear at reset,
    // since only entries below the count are ever used.
    lstk_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Pack the result beat, first field in the lowest bits.
    assign m_tdata = {{M_PAD_W{1'b0}}, result.position, result.data};
    assign m_tuser = {result.is_full, result.is_empty, result.status};

endmodule

// File: rtl/lstk_mem.sv
`timescale 1ns / 1ps

module lstk_mem #(
    parameter int   DEPTH  = lstk_pkg::DEPTH_DEF,
    localparam int  ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [lstk_pkg::DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [lstk_pkg::DATA_W-1:0] rd_data
);
    import lstk_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, one address per cycle
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: rtl/lstk_ctrl.sv
`timescale 1ns / 1ps

module lstk_ctrl #(
    parameter int   DEPTH  = lstk_pkg::DEPTH_DEF,
    localparam int  ADDR_W = $clog2(DEPTH),
    localparam int  CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lstk_pkg::cmd_t              s_cmd,
    input  logic [lstk_pkg::DATA_W-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lstk_pkg::result_t           m_result,
    output logic                        mem_wr_en,
    output logic [ADDR_W-1:0]           mem_wr_addr,
    output logic [lstk_pkg::DATA_W-1:0] mem_wr_data,
    output logic [ADDR_W-1:0]           mem_rd_addr,
    input  logic [lstk_pkg::DATA_W-1:0] mem_rd_data
);
    import lstk_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [DATA_W-1:0] key_reg, key_next;
    logic [DATA_W-1:0] res_data_reg, res_data_next;
    logic [CNT_W-1:0]  res_pos_reg, res_pos_next;
    status_t           res_status_reg, res_status_next;

    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] top_addr;
    logic              out_free;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign top_addr = ADDR_W'(count_reg - CNT_W'(1));
    assign out_free = !out_valid_reg || m_ready;

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = out_valid_reg;
    assign m_result    = out_reg;
    assign mem_wr_addr = count_reg[ADDR_W-1:0];
    assign mem_wr_data = s_value;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        res_data_next   = res_data_reg;
        res_pos_next    = res_pos_reg;
        res_status_next = res_status_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        mem_wr_en       = 1'b0;
        mem_rd_addr     = top_addr;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_data_next   = '0;
                    res_pos_next    = '0;
                    res_status_next = ST_OK;
                    state_next      = S_FINISH;
                    case (s_cmd)
                        CMD_PUSH: begin
                            if (full) begin
                                res_status_next = ST_OVERFLOW;
                            end else begin
                                mem_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (empty) begin
                                res_status_next = ST_UNDERFLOW;
                                res_data_next   = DATA_UNDERFLOW;
                            end else begin
                                state_next = S_READ;
                                if (s_cmd == CMD_POP) begin
                                    count_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        CMD_SEARCH: begin
                            key_next = s_value;
                            if (empty) begin
                                res_status_next = ST_UNDERFLOW;
                            end else begin
                                idx_next   = top_addr;
                                pos_next   = CNT_W'(1);
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                res_data_next = mem_rd_data;
                state_next    = S_FINISH;
            end
            S_SCAN: begin
                // read data belongs to idx_reg; fetch the entry below it
                mem_rd_addr = idx_reg - ADDR_W'(1);
                if (mem_rd_data == key_reg) begin
                    res_status_next = ST_OK;
                    res_pos_next    = pos_reg;
                    state_next      = S_FINISH;
                end else if (idx_reg == '0) begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_FINISH;
                end else begin
                    idx_next = idx_reg - ADDR_W'(1);
                    pos_next = pos_reg + CNT_W'(1);
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_next.data     = res_data_reg;
                    out_next.position = POS_W'(res_pos_reg);
                    out_next.status   = res_status_reg;
                    out_next.is_empty = empty;
                    out_next.is_full  = full;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        res_data_reg   <= res_data_next;
        res_pos_reg    <= res_pos_next;
        res_status_reg <= res_status_next;
        out_reg        <= out_next;
    end

endmodule

// File: rtl/lstk_chk.sv
`timescale 1ns / 1ps
`include "lifo_stack_with_search_assert.svh"

module lstk_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lstk_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lstk_pkg::M_TUSER_W-1:0] m_tuser
);
    import lstk_pkg::*;

    `LSTK_ASSERT_NEXT_ALWAYS(a_reset_drops_result, aclk, !aresetn, !m_tvalid, "result valid after reset")
    `LSTK_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `LSTK_ASSERT_NOW(a_flags_exclusive, aclk, aresetn, m_tvalid, !(m_tuser[STATUS_W] && m_tuser[STATUS_W+1]), "empty and full both set")
    `LSTK_ASSERT_NOW(a_position_ok, aclk, aresetn, m_tvalid && (m_tdata[DATA_W +: POS_W] != '0), m_tuser[STATUS_W-1:0] == ST_OK, "match position without ok status")
    `LSTK_ASSERT_NOW(a_overflow_full, aclk, aresetn, m_tvalid && (m_tuser[STATUS_W-1:0] == ST_OVERFLOW), m_tuser[STATUS_W+1], "overflow while not full")

endmodule

bind lifo_stack_with_search lstk_chk u_lstk_chk (.*);

// File: bench/lifo_stack_with_search_tb.sv
`timescale 1ns / 1ps

module lifo_stack_with_search_tb;

    import lstk_pkg::*;

    localparam int STACK_DEPTH  = DEPTH_DEF;
    localparam int IDLE_PCT     = 16;
    localparam int STALL_LIMIT  = 1000;   // cycles without any beat before giving up
    localparam int DRAIN_CYCLES = 40;     // longest search plus output stalls
    localparam int PRINT_CAP    = 60;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;      // value
    logic [S_TUSER_W-1:0] s_tuser  = CMD_PUSH; // cmd
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // data, position, zero pad
    logic [M_TUSER_W-1:0] m_tuser;            // status, is_empty, is_full

    // Shadow copy of the stack, advanced once per accepted command.
    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int unsigned       shadow_count = 0;
    result_t           pending_results [$];

    bit back_to_back    = 1'b0;   // both sides stop idling while set
    int mismatch_count  = 0;
    int results_seen    = 0;
    int quiet_cycles    = 0;

    lifo_stack_with_search #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Apply one command to the shadow stack and return the result it must give.
    function automatic result_t apply_to_shadow(cmd_t op, logic [DATA_W-1:0] word);
        result_t r;
        bit      found;
        r        = '0;
        r.status = ST_OK;
        found    = 1'b0;
        case (op)
            CMD_PUSH: begin
                if (shadow_count == STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    shadow_stack[shadow_count] = word;
                    shadow_count++;
                end
            end
            CMD_POP, CMD_PEEK: begin
                if (shadow_count == 0) begin
                    r.status = ST_UNDERFLOW;
                    r.data   = DATA_UNDERFLOW;
                end else begin
                    r.data = shadow_stack[shadow_count - 1];
                    if (op == CMD_POP) shadow_count--;
                end
            end
            default: begin
                // Walk from the top down; the first hit wins.
                if (shadow_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.status = ST_NOTFOUND;
                    for (int k = 0; k < shadow_count; k++) begin
                        if (!found && shadow_stack[shadow_count - 1 - k] == word) begin
                            found      = 1'b1;
                            r.status   = ST_OK;
                            r.position = POS_W'(k + 1);
                        end
                    end
                end
            end
        endcase
        r.is_empty = (shadow_count == 0);
        r.is_full  = (shadow_count == STACK_DEPTH);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("ERROR at %0t ns, result %0d, %s: got %0h, expected %0h",
                     $time, results_seen, field, got, want);
    endtask

    // Hold a command on the bus until it is taken, then advance the shadow stack.
    task automatic send_command(cmd_t op, logic [DATA_W-1:0] word);
        while (!back_to_back && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(apply_to_shadow(op, word));
    endtask

    task automatic check_result_beat();
        result_t want;
        results_seen++;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", m_tdata[DATA_W-1:0], '0);
        end else begin
            want = pending_results.pop_front();
            if (m_tdata[DATA_W-1:0] !== want.data)
                report_mismatch("data", m_tdata[DATA_W-1:0], want.data);
            if (m_tdata[DATA_W +: POS_W] !== want.position)
                report_mismatch("position", DATA_W'(m_tdata[DATA_W +: POS_W]),
                                DATA_W'(want.position));
            if (m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0)
                report_mismatch("tdata pad", DATA_W'(m_tdata[M_TDATA_W-1 -: M_PAD_W]), '0);
            if (m_tuser[STATUS_W-1:0] !== want.status)
                report_mismatch("status", DATA_W'(m_tuser[STATUS_W-1:0]),
                                DATA_W'(want.status));
            if (m_tuser[STATUS_W] !== want.is_empty)
                report_mismatch("is_empty", DATA_W'(m_tuser[STATUS_W]),
                                DATA_W'(want.is_empty));
            if (m_tuser[STATUS_W+1] !== want.is_full)
                report_mismatch("is_full", DATA_W'(m_tuser[STATUS_W+1]),
                                DATA_W'(want.is_full));
        end
    endtask

    // Result side: check each beat, then pick the next cycle's tready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result_beat();
        if (!aresetn)
            m_tready <= 1'b0;
        else if (back_to_back)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("TIMEOUT: no beat for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Underflow on every read kind while nothing is stored.
    task automatic test_empty_stack();
        send_command(CMD_POP,    32'h1234_5678);
        send_command(CMD_PEEK,   32'hFFFF_FFFF);
        send_command(CMD_SEARCH, 32'h0000_0000);
    endtask

    // Fill to the brim with extreme and repeated words, then push once more.
    task automatic test_fill_and_overflow();
        logic [DATA_W-1:0] words [8];
        words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0000_0005, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0005};
        foreach (words[i]) send_command(CMD_PUSH, words[i]);
        while (shadow_count < STACK_DEPTH) send_command(CMD_PUSH, $urandom);
        send_command(CMD_PUSH, 32'hDEAD_BEEF);
    endtask

    // Hit at the top, at the bottom, on a repeated word, and a miss; then a peek and a pop.
    task automatic test_search_and_read();
        send_command(CMD_SEARCH, shadow_stack[shadow_count - 1]);
        send_command(CMD_SEARCH, 32'h8000_0000);
        send_command(CMD_SEARCH, 32'h0000_0005);
        send_command(CMD_SEARCH, 32'h1357_9BDF);
        send_command(CMD_PEEK,   $urandom);
        send_command(CMD_POP,    $urandom);
    endtask

    function automatic logic [DATA_W-1:0] pick_word();
        // A small pool makes repeated words, and so first-match searches, common.
        if ($urandom_range(0, 2) == 0) return DATA_W'($urandom_range(0, 7));
        return $urandom;
    endfunction

    function automatic logic [DATA_W-1:0] pick_search_key();
        if (shadow_count != 0 && $urandom_range(0, 99) < 60)
            return shadow_stack[$urandom_range(0, shadow_count - 1)];
        return pick_word();
    endfunction

    // Mixed traffic; push_pct steers the fill level between empty and full.
    task automatic run_random_mix(int count, int push_pct);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                send_command(CMD_SEARCH, pick_search_key());
            else if (roll < 35)
                send_command(CMD_PEEK, $urandom);
            else if ($urandom_range(0, 99) < push_pct)
                send_command(CMD_PUSH, pick_word());
            else
                send_command(CMD_POP, $urandom);
        end
    endtask

    // Swing the stack between full and empty, with idling on both sides.
    task automatic test_random_swings();
        for (int phase = 0; phase < 16; phase++)
            run_random_mix(64, phase[0] ? 25 : 75);
    endtask

    // Long stretch with both sides always ready.
    task automatic test_back_to_back();
        back_to_back = 1'b1;
        run_random_mix(150, 75);
        run_random_mix(150, 25);
        back_to_back = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_stack();
        test_fill_and_overflow();
        test_search_and_read();
        test_random_swings();
        test_back_to_back();
        run_random_mix(1, 50);   // land with idling back on

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: lifo_stack_with_search.f
+incdir+rtl
rtl/lstk_pkg.sv
rtl/lstk_mem.sv
rtl/lstk_ctrl.sv
rtl/lifo_stack_with_search.sv
rtl/lstk_chk.sv
bench/lifo_stack_with_search_tb.sv
